>>> hdl/http_byte_range_parser_defines.svh
// assertion helpers shared by the range parser rtl
`ifndef HTTP_BYTE_RANGE_PARSER_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define BRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define BRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/brp_pkg.sv
package brp_pkg;

   localparam int SizeWidth = 48;
   localparam int EndWidth  = 49;
   localparam int AccWidth  = 64;

   localparam logic [2:0] PrefixLen = 3'd6;
   localparam logic [AccWidth-1:0] LimitDiv10 = 64'd922337203685477580;

   localparam logic [7:0] CharDash  = 8'h2d;
   localparam logic [7:0] CharPlus  = 8'h2b;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5a;
   localparam logic [7:0] CaseShift = 8'h20;

   // register index of resource_size
   localparam logic CsrResourceSize = 1'b0;

   typedef enum logic [3:0] {
      PhLead   = 4'b0001,
      PhPrefix = 4'b0010,
      PhStart  = 4'b0100,
      PhEnd    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic closed;
      logic digit;
      logic seen;
   } token_flags_type;

   typedef struct packed {
      phase_type              phase;
      logic [2:0]             prefix_index;
      logic [AccWidth-1:0]    start_value;
      logic [AccWidth-1:0]    end_value;
      token_flags_type        start_flags;
      token_flags_type        end_flags;
      logic                   error;
   } parse_state_type;

   typedef struct packed {
      logic                       specified;
      logic                       valid;
      logic [SizeWidth-1:0]       start;
      logic signed [EndWidth-1:0] range_end;
   } result_type;

   localparam parse_state_type StateIdle = '{
      phase:        PhLead,
      prefix_index: 3'd0,
      start_value:  '0,
      end_value:    '0,
      start_flags:  '0,
      end_flags:    '0,
      error:        1'b0
   };

   // lower-case "bytes="
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h62;
         3'd1:    ch = 8'h79;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h65;
         3'd4:    ch = 8'h73;
         3'd5:    ch = 8'h3d;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> hdl/brp_step.sv
module brp_step (
   input  brp_pkg::parse_state_type cur,
   input  logic [7:0]               char_in,
   output brp_pkg::parse_state_type nxt
);

   logic                          blank;
   logic                          is_digit;
   logic [7:0]                    lc;
   logic [7:0]                    digit8;
   logic [3:0]                    digit;
   logic                          use_end;
   logic [brp_pkg::AccWidth-1:0]  acc;
   logic [brp_pkg::AccWidth-1:0]  acc_next;
   brp_pkg::token_flags_type      flags;
   brp_pkg::token_flags_type      flags_next;
   logic                          tok_err;
   brp_pkg::phase_type            ph;

   assign blank    = char_in inside {8'd32, [8'd9:8'd13]};
   assign is_digit = char_in inside {[brp_pkg::CharZero:brp_pkg::CharNine]};
   assign lc       = (char_in inside {[brp_pkg::CharUpA:brp_pkg::CharUpZ]}) ?
                     char_in + brp_pkg::CaseShift : char_in;
   assign digit8   = char_in - brp_pkg::CharZero;
   assign digit    = digit8[3:0];
   assign use_end  = (cur.phase == brp_pkg::PhEnd);
   assign acc      = use_end ? cur.end_value : cur.start_value;
   assign flags    = use_end ? cur.end_flags : cur.start_flags;

   // one token byte: sign, digit accumulate (x8 + x2 + d) or close on whitespace
   always_comb begin
      acc_next   = acc;
      flags_next = flags;
      tok_err    = 1'b0;
      if (blank) begin
         if (flags.seen) flags_next.closed = 1'b1;
      end else if (flags.closed) begin
         tok_err = 1'b1;
      end else if (char_in == brp_pkg::CharPlus) begin
         if (flags.seen) tok_err = 1'b1;
         else flags_next.seen = 1'b1;
      end else if (is_digit) begin
         flags_next.seen  = 1'b1;
         flags_next.digit = 1'b1;
         if (acc > brp_pkg::LimitDiv10 ||
             (acc == brp_pkg::LimitDiv10 && digit > 4'd7)) begin
            tok_err = 1'b1;
         end else begin
            acc_next = {acc[brp_pkg::AccWidth-4:0], 3'b000}
                     + {acc[brp_pkg::AccWidth-2:0], 1'b0}
                     + {{(brp_pkg::AccWidth-4){1'b0}}, digit};
         end
      end else begin
         tok_err = 1'b1;
      end
   end

   always_comb begin
      nxt = cur;
      ph  = cur.phase;
      if (cur.phase == brp_pkg::PhLead && !blank) begin
         ph        = brp_pkg::PhPrefix;
         nxt.phase = brp_pkg::PhPrefix;
      end
      if (!(cur.phase == brp_pkg::PhLead && blank) && !cur.error) begin
         case (ph)
            brp_pkg::PhPrefix: begin
               if (cur.prefix_index >= brp_pkg::PrefixLen ||
                   lc != brp_pkg::prefix_char(cur.prefix_index)) begin
                  nxt.error = 1'b1;
               end else begin
                  nxt.prefix_index = cur.prefix_index + 3'd1;
                  if (cur.prefix_index == brp_pkg::PrefixLen - 3'd1)
                     nxt.phase = brp_pkg::PhStart;
               end
            end
            brp_pkg::PhStart: begin
               if (char_in == brp_pkg::CharDash) begin
                  nxt.phase = brp_pkg::PhEnd;
               end else begin
                  nxt.start_value = acc_next;
                  nxt.start_flags = flags_next;
                  nxt.error       = tok_err;
               end
            end
            brp_pkg::PhEnd: begin
               nxt.end_value = acc_next;
               nxt.end_flags = flags_next;
               nxt.error     = tok_err;
            end
            default: ;
         endcase
      end
   end

endmodule

>>> hdl/brp_eval.sv
module brp_eval (
   input  brp_pkg::parse_state_type      fin,
   input  logic [brp_pkg::SizeWidth-1:0] size,
   output brp_pkg::result_type           res
);

   logic [brp_pkg::AccWidth-1:0]  size_w;
   logic [brp_pkg::EndWidth-1:0]  def_end;
   logic [brp_pkg::SizeWidth-1:0] size_m1;
   logic                          start_lt_size;
   logic                          end_ge_start;
   logic                          end_ge_size;
   logic                          size_gt_end;
   logic                          end_ok;
   logic [brp_pkg::SizeWidth-1:0] clamp_end;

   assign size_w        = {{(brp_pkg::AccWidth-brp_pkg::SizeWidth){1'b0}}, size};
   // wraps to -1 for an empty resource
   assign def_end       = {1'b0, size} - {{(brp_pkg::EndWidth-1){1'b0}}, 1'b1};
   assign size_m1       = size - {{(brp_pkg::SizeWidth-1){1'b0}}, 1'b1};
   assign start_lt_size = fin.start_value < size_w;
   assign end_ge_start  = fin.end_value >= fin.start_value;
   assign end_ge_size   = fin.end_value >= size_w;
   assign size_gt_end   = size_w > fin.end_value;
   assign end_ok        = !fin.end_flags.seen || (fin.end_flags.digit && end_ge_start);
   assign clamp_end     = (!fin.end_flags.seen || end_ge_size) ? size_m1 :
                          fin.end_value[brp_pkg::SizeWidth-1:0];

   always_comb begin
      res.specified = 1'b1;
      res.valid     = 1'b0;
      res.start     = '0;
      res.range_end = def_end;
      if (fin.phase == brp_pkg::PhLead) begin
         res.specified = 1'b0;
         res.valid     = 1'b1;
      end else if (!fin.error && fin.phase == brp_pkg::PhEnd) begin
         if (!fin.start_flags.seen) begin
            // suffix form: last n bytes
            if (fin.end_flags.digit && fin.end_value != '0) begin
               res.valid = 1'b1;
               res.start = size_gt_end ?
                           size - fin.end_value[brp_pkg::SizeWidth-1:0] : '0;
            end
         end else if (fin.start_flags.digit && start_lt_size && end_ok) begin
            res.valid     = 1'b1;
            res.start     = fin.start_value[brp_pkg::SizeWidth-1:0];
            res.range_end = {1'b0, clamp_end};
         end
      end
   end

endmodule

>>> hdl/http_byte_range_parser.sv
// channel    dir  handshake        payload
// req_       in   tvalid/tready    tdata[7:0] header byte, tlast last byte
// rsp_       out  tvalid/tready    tdata start/end, tuser specified/valid
// csr_       in   apb, pready=1    resource_size at byte address 0
//
// one header byte per cycle while no last beat waits on a stalled result; a result is
// presented once the last beat has passed the input register, snapshot and result register.
// the parser state is a single 64-bit multiply-by-ten accumulate per byte,
// and the range decision works on a snapshot taken at the last byte.
// reset is synchronous and clears all handshake state, the parser state and
// resource_size. a stalled result only holds back a following last beat.
`include "http_byte_range_parser_defines.svh"

module http_byte_range_parser (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] header_byte
   input  logic         req_tlast,   // last_byte

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [47:0] range_start, [96:48] range_end, rest zero
   output logic [1:0]   rsp_tuser,   // [0] range_specified, [1] range_valid

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic                          size_wr;
   logic [brp_pkg::SizeWidth-1:0] size_ff;
   logic [brp_pkg::SizeWidth-1:0] size_in;

   logic                          in_v_ff;
   logic                          in_v_in;
   logic [7:0]                    in_byte_ff;
   logic                          in_last_ff;
   logic                          req_accept;
   logic                          in_move;

   brp_pkg::parse_state_type      state_ff;
   brp_pkg::parse_state_type      state_in;
   brp_pkg::parse_state_type      step_next;

   logic                          snap_v_ff;
   logic                          snap_v_in;
   brp_pkg::parse_state_type      snap_ff;
   logic                          snap_ready;
   logic                          snap_move;

   brp_pkg::result_type           eval_res;
   brp_pkg::result_type           rsp_ff;
   logic                          rsp_v_ff;
   logic                          rsp_v_in;
   logic                          out_ready;

   // configuration
   assign csr_pready = 1'b1;
   assign size_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[3] == brp_pkg::CsrResourceSize);
   assign size_in    = size_wr ? csr_pwdata[brp_pkg::SizeWidth-1:0] : size_ff;
   assign csr_prdata = (csr_paddr[3] == brp_pkg::CsrResourceSize) ?
                       {{(64-brp_pkg::SizeWidth){1'b0}}, size_ff} : '0;

   // handshake chain
   assign out_ready  = !rsp_v_ff || rsp_tready;
   assign snap_ready = !snap_v_ff || out_ready;
   assign snap_move  = snap_v_ff && out_ready;
   assign in_move    = in_v_ff && (!in_last_ff || snap_ready);
   assign req_tready = !in_v_ff || in_move;
   assign req_accept = req_tvalid && req_tready;

   assign in_v_in   = req_accept ? 1'b1 : (in_move ? 1'b0 : in_v_ff);
   assign snap_v_in = (in_move && in_last_ff) ? 1'b1 : (snap_move ? 1'b0 : snap_v_ff);
   assign rsp_v_in  = snap_move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);

   brp_step u_step (
      .cur     (state_ff),
      .char_in (in_byte_ff),
      .nxt     (step_next)
   );

   // the last beat hands its state to the snapshot and restarts the parser
   assign state_in = !in_move  ? state_ff :
                     in_last_ff ? brp_pkg::StateIdle : step_next;

   brp_eval u_eval (
      .fin  (snap_ff),
      .size (size_ff),
      .res  (eval_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= '0;
         in_v_ff   <= 1'b0;
         snap_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         state_ff  <= brp_pkg::StateIdle;
      end else begin
         size_ff   <= size_in;
         in_v_ff   <= in_v_in;
         snap_v_ff <= snap_v_in;
         rsp_v_ff  <= rsp_v_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (in_move && in_last_ff) snap_ff <= step_next;
      if (snap_move) rsp_ff <= eval_res;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.range_end, rsp_ff.start};
   assign rsp_tuser  = {rsp_ff.valid, rsp_ff.specified};

   `BRP_ASSERT_NEXT(a_restart_after_last, clock, reset, in_move && in_last_ff,
      state_ff.phase == brp_pkg::PhLead && !state_ff.error && state_ff.prefix_index == 3'd0,
      "parser state not cleared after last beat")
   `BRP_ASSERT_NOW(a_result_from_snapshot, clock, reset, $rose(rsp_v_ff),
      $past(snap_v_ff), "result appeared without a snapshot")
   `BRP_ASSERT_NOW(a_invalid_start_zero, clock, reset, rsp_v_ff && !rsp_ff.valid,
      rsp_ff.start == '0 && rsp_ff.specified, "invalid range with nonzero start")
   `BRP_ASSERT_NOW(a_blank_is_valid, clock, reset, rsp_v_ff && !rsp_ff.specified,
      rsp_ff.valid && rsp_ff.start == '0, "blank header not reported as valid")

endmodule

>>> bench/tb_http_byte_range_parser.sv
`timescale 1ns / 1ps

module tb_http_byte_range_parser;

   // resource_size is wider than 32 bits, so registers sit on an 8-byte pitch
   localparam logic [3:0]  SizeAddr     = 4'h0;
   localparam logic [3:0]  SpareAddr    = 4'h8;
   localparam logic [47:0] UnitText     = "bytes=";
   localparam int          LongHold     = 300;
   localparam int          SettleCycles = 8;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] header_byte
   logic         req_tlast;   // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;   // [47:0] range_start, [96:48] range_end
   logic [1:0]   rsp_tuser;   // [0] range_specified, [1] range_valid
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [63:0]  csr_pwdata;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   int fail_count    = 0;
   bit req_gaps_on   = 1'b1;
   bit rsp_gaps_on   = 1'b1;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int stall_left    = 0;

   // parser copy
   logic [47:0]              size_model  = '0;
   brp_pkg::phase_type       hdr_phase   = brp_pkg::PhLead;
   int                       unit_idx    = 0;
   logic [63:0]              first_acc   = '0;
   logic [63:0]              last_acc    = '0;
   brp_pkg::token_flags_type first_flags = '0;
   brp_pkg::token_flags_type last_flags  = '0;
   logic                     hdr_bad     = 1'b0;

   brp_pkg::result_type range_expect_q[$];
   logic [7:0]          hdr_q[$];

   http_byte_range_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic void scan_token(input logic [7:0] c,
                                      inout brp_pkg::token_flags_type f,
                                      inout logic [63:0] acc);
      logic [63:0] d;
      if (is_blank(c)) begin
         if (f.seen) f.closed = 1'b1;
         return;
      end
      if (f.closed) begin
         hdr_bad = 1'b1;
         return;
      end
      if (c == brp_pkg::CharPlus) begin
         if (f.seen) hdr_bad = 1'b1;
         else f.seen = 1'b1;
      end else if (c >= brp_pkg::CharZero && c <= brp_pkg::CharNine) begin
         d = {56'h0, c - brp_pkg::CharZero};
         f.seen  = 1'b1;
         f.digit = 1'b1;
         // anything past 2^63-1 poisons the header
         if (acc > brp_pkg::LimitDiv10 || (acc == brp_pkg::LimitDiv10 && d > 64'd7))
            hdr_bad = 1'b1;
         else acc = acc * 64'd10 + d;
      end else begin
         hdr_bad = 1'b1;
      end
   endfunction

   function automatic void predict_range_byte(input logic [7:0] c, input logic last);
      logic [7:0]          lc;
      logic [63:0]         sz;
      logic [63:0]         e;
      logic [63:0]         tmp;
      logic                end_ok;
      brp_pkg::result_type r;
      if (!(hdr_phase == brp_pkg::PhLead && is_blank(c))) begin
         if (hdr_phase == brp_pkg::PhLead) hdr_phase = brp_pkg::PhPrefix;
         if (!hdr_bad) begin
            case (hdr_phase)
               brp_pkg::PhPrefix: begin
                  lc = (c >= brp_pkg::CharUpA && c <= brp_pkg::CharUpZ) ?
                       c + brp_pkg::CaseShift : c;
                  if (unit_idx >= int'(brp_pkg::PrefixLen) ||
                      lc != UnitText[8*(5-unit_idx) +: 8]) begin
                     hdr_bad = 1'b1;
                  end else begin
                     unit_idx++;
                     if (unit_idx == int'(brp_pkg::PrefixLen)) hdr_phase = brp_pkg::PhStart;
                  end
               end
               brp_pkg::PhStart: begin
                  if (c == brp_pkg::CharDash) hdr_phase = brp_pkg::PhEnd;
                  else scan_token(c, first_flags, first_acc);
               end
               default: scan_token(c, last_flags, last_acc);
            endcase
         end
      end
      if (!last) return;

      sz  = {16'h0, size_model};
      tmp = sz - 64'd1;
      r.specified = 1'b1;
      r.valid     = 1'b0;
      r.start     = '0;
      r.range_end = (sz != 0) ? tmp[48:0] : '1;
      if (hdr_phase == brp_pkg::PhLead) begin
         r.specified = 1'b0;
         r.valid     = 1'b1;
      end else if (!hdr_bad && hdr_phase == brp_pkg::PhEnd) begin
         if (!first_flags.seen) begin
            // suffix form: last N bytes
            if (last_flags.digit && last_acc != 0) begin
               r.valid = 1'b1;
               tmp     = sz - last_acc;
               r.start = (sz > last_acc) ? tmp[47:0] : '0;
            end
         end else if (first_flags.digit) begin
            end_ok = 1'b1;
            e      = (sz != 0) ? sz - 64'd1 : '0;
            if (last_flags.seen) begin
               if (last_flags.digit) e = last_acc;
               else end_ok = 1'b0;
            end
            if (end_ok && first_acc < sz && e >= first_acc) begin
               r.valid     = 1'b1;
               r.start     = first_acc[47:0];
               tmp         = sz - 64'd1;
               r.range_end = (e >= sz) ? tmp[48:0] : e[48:0];
            end
         end
      end
      range_expect_q.push_back(r);

      hdr_phase   = brp_pkg::PhLead;
      unit_idx    = 0;
      first_acc   = '0;
      last_acc    = '0;
      first_flags = '0;
      last_flags  = '0;
      hdr_bad     = 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin : result_check
      brp_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (range_expect_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            want = range_expect_q.pop_front();
            check_field("range_specified", {63'h0, want.specified}, {63'h0, rsp_tuser[0]});
            check_field("range_valid", {63'h0, want.valid}, {63'h0, rsp_tuser[1]});
            check_field("range_start", {16'h0, want.start}, {16'h0, rsp_tdata[47:0]});
            check_field("range_end", {15'h0, want.range_end}, {15'h0, rsp_tdata[96:48]});
         end
      end
   end

   always @(posedge clock) begin : rsp_pacing
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_requests != hold_seen) begin
         hold_seen  = hold_requests;
         hold_left  = LongHold;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
         stall_left = idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_range_byte(b, last);
      gap = (req_gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_header();
      // an empty header goes out as a single blank
      if (hdr_q.size() == 0) hdr_q.push_back(8'h20);
      for (int i = 0; i < hdr_q.size(); i++) send_beat(hdr_q[i], i == hdr_q.size() - 1);
      hdr_q.delete();
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
   endtask

   task automatic header(input string s);
      put_text(s);
      send_header();
   endtask

   task automatic put_num(input logic [63:0] v);
      logic [7:0]  digits[$];
      logic [63:0] rest;
      logic [63:0] d;
      rest = v;
      do begin
         d = rest % 10;
         digits.push_front(brp_pkg::CharZero + d[7:0]);
         rest = rest / 10;
      end while (rest != 0);
      foreach (digits[i]) hdr_q.push_back(digits[i]);
   endtask

   function automatic logic [7:0] random_blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? 8'h20 : 8'h09 + k[7:0];
   endfunction

   task automatic put_blanks(input int n);
      repeat (n) hdr_q.push_back(random_blank());
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (range_expect_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [3:0] addr,
                             input logic [63:0] wdata, output logic [63:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_size(input logic [47:0] sz);
      logic [63:0] rd;
      logic [31:0] junk;
      junk = $urandom;
      wait_drained();
      // upper bits are don't-care and must be dropped
      csr_access(1'b1, SizeAddr, {junk[15:0], sz}, rd);
      size_model = sz;
      csr_access(1'b0, SizeAddr, '0, rd);
      check_field("resource_size", {16'h0, sz}, {16'h0, rd[47:0]});
   endtask

   function automatic logic [63:0] pick_value();
      logic [63:0] sz;
      sz = {16'h0, size_model};
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 64'($urandom_range(1, 20));
         2:       return sz + 64'($urandom_range(0, 4)) - 64'd2;
         3, 4:    return (sz == 0) ? 64'($urandom_range(0, 9)) : {$urandom, $urandom} % sz;
         5:       return {$urandom, $urandom} >> 1;
         6:       return 64'h7fff_ffff_ffff_fffe + 64'($urandom_range(0, 3));
         default: return 64'($urandom_range(0, 5000));
      endcase
   endfunction

   task automatic random_header();
      int         kind;
      int         form;
      int         n;
      logic [7:0] ch;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         put_blanks($urandom_range(0, 4));
      end else if (kind < 14) begin
         n = $urandom_range(1, 10);
         repeat (n) hdr_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 3) == 0) put_blanks($urandom_range(1, 3));
         for (int k = 0; k < 6; k++) begin
            ch = UnitText[8*(5-k) +: 8];
            if (ch >= 8'h61 && $urandom_range(0, 3) == 0) ch = ch - brp_pkg::CaseShift;
            hdr_q.push_back(ch);
         end
         if ($urandom_range(0, 9) == 0) put_blanks(1);
         form = $urandom_range(0, 2);
         if (form != 0) begin
            if ($urandom_range(0, 5) == 0) put_text("+");
            if ($urandom_range(0, 7) == 0) put_text("00");
            put_num(pick_value());
            if ($urandom_range(0, 7) == 0) put_blanks(1);
         end
         put_text("-");
         if (form != 1) begin
            if ($urandom_range(0, 7) == 0) put_blanks(1);
            if ($urandom_range(0, 5) == 0) put_text("+");
            put_num(pick_value());
            if ($urandom_range(0, 19) == 0) put_text("9");
         end
         if ($urandom_range(0, 4) == 0) put_blanks($urandom_range(1, 3));
         // a share of well-formed headers get one byte corrupted
         if (kind >= 84)
            hdr_q[$urandom_range(0, hdr_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      send_header();
   endtask

   task automatic test_empty_resource();
      header("bytes=-5");
      header("bytes=0-");
      header("");
   endtask

   task automatic test_well_formed();
      apply_size(48'd1000);
      header("bytes=0-499");
      header("bytes=-200");
      header("bytes=900-");
      header("BYTES=+10-+20");
      hdr_q.push_back(8'h09);
      hdr_q.push_back(8'h20);
      put_text("bytes= 5 -2000");
      hdr_q.push_back(8'h0d);
      hdr_q.push_back(8'h0a);
      hdr_q.push_back(8'h0b);
      hdr_q.push_back(8'h0c);
      send_header();
      header("bytes=-5000");
      for (int k = 0; k < 5; k++) hdr_q.push_back(8'h09 + k[7:0]);
      hdr_q.push_back(8'h20);
      send_header();
   endtask

   task automatic test_malformed();
      header("bytes=1000-");
      header("bytes=5-4");
      header("bytes=-0");
      header("bytes=-");
      header("bytes=+-5");
      header("bytes=5-+");
      header("bytes=1 2-3");
      header("bytes=++1-2");
      header("bytes=1+-2");
      header("bytes=1-2-3");
      header("bytes=1x-2 junk");
      header("bytes");
      header("bytez=1-2");
      header("bytes=12");
      header("bytes=0-9223372036854775808");
      header("bytes =1-2");
   endtask

   task automatic test_size_extremes();
      logic [63:0] rd;
      wait_drained();
      // writes to an unmapped slot must leave resource_size alone
      csr_access(1'b1, SpareAddr, {$urandom, $urandom}, rd);
      header("bytes=990-");
      apply_size('1);
      header("bytes=0-9223372036854775807");
      header("bytes=-1");
      apply_size(48'd1);
      header("bytes=0-0");
      header("bytes=1-");
   endtask

   task automatic test_random_traffic();
      logic [47:0] sz;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       sz = '0;
            1:       sz = 48'd1;
            2:       sz = '1;
            3:       sz = 48'($urandom_range(2, 100));
            4:       sz = 48'({$urandom, $urandom});
            default: sz = 48'($urandom_range(100, 100000));
         endcase
         apply_size(sz);
         req_gaps_on = (ph != 1) && ($urandom_range(0, 3) != 0);
         rsp_gaps_on = (ph != 1) && ($urandom_range(0, 3) != 0);
         random_header();
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      apply_size(48'($urandom_range(50, 200)));
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      hold_requests++;
      repeat (4) begin
         put_text("bytes=");
         put_num(64'($urandom_range(0, 60)));
         put_text("-");
         put_num(64'($urandom_range(0, 90)));
         send_header();
      end
      wait_drained();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_resource();
      test_well_formed();
      test_malformed();
      test_size_extremes();
      test_random_traffic();
      test_backpressure();

      wait_drained();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/brp_pkg.sv
hdl/brp_step.sv
hdl/brp_eval.sv
hdl/http_byte_range_parser.sv
bench/tb_http_byte_range_parser.sv
